>>> src/tun_pkg.sv
// Package for the triangle unit normal block: default widths and the prescale
// width. No dependencies.
`default_nettype none
package tun_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  // prescaled component magnitudes are held in this many bits
  localparam int PRESCALE_BITS = 31;
endpackage
`default_nettype wire

>>> src/tun_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on nothing outside this file.
`default_nettype none
module tun_sqrt #(
  parameter int IN_WIDTH = 64,
  parameter int TAG_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [IN_WIDTH-1:0]   radicand,
  input  logic [TAG_WIDTH-1:0]  in_tag,
  output logic                  out_valid,
  output logic [IN_WIDTH/2-1:0] root,
  output logic [TAG_WIDTH-1:0]  out_tag
);
  localparam int NSTEP = IN_WIDTH / 2;
  localparam int RW = IN_WIDTH / 2 + 2;

  logic [NSTEP:0]               vld;
  logic [IN_WIDTH-1:0]          rad [NSTEP+1];
  logic [RW-1:0]                rem [NSTEP+1];
  logic [NSTEP-1:0]             res [NSTEP+1];
  logic [TAG_WIDTH-1:0]         tag [NSTEP+1];

  assign vld[0] = in_valid;
  assign rad[0] = radicand;
  assign rem[0] = '0;
  assign res[0] = '0;
  assign tag[0] = in_tag;

  // restoring square root, two radicand bits a stage
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic [RW-1:0] trial;
    logic [RW-1:0] cand;
    always_comb begin
      trial = {rem[i][RW-3:0], rad[i][IN_WIDTH-1 -: 2]};
      cand  = {res[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      rad[i+1] <= rad[i] << 2;
      tag[i+1] <= tag[i];
      if (trial >= cand) begin
        rem[i+1] <= trial - cand;
        res[i+1] <= {res[i][NSTEP-2:0], 1'b1};
      end else begin
        rem[i+1] <= trial;
        res[i+1] <= {res[i][NSTEP-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[NSTEP];
  assign root = res[NSTEP];
  assign out_tag = tag[NSTEP];
endmodule
`default_nettype wire

>>> src/tun_div.sv
// Pipelined restoring divider for one normal component, one quotient bit
// per stage, carrying a payload tag. Depends on nothing outside this file.
`default_nettype none
module tun_div #(
  parameter int NUM_WIDTH = 46,
  parameter int DEN_WIDTH = 32,
  parameter int Q_WIDTH = 16,
  parameter int TAG_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [NUM_WIDTH-1:0] numer,
  input  logic [DEN_WIDTH-1:0] denom,
  input  logic [TAG_WIDTH-1:0] in_tag,
  output logic                 out_valid,
  output logic [Q_WIDTH-1:0]   quot,
  output logic [TAG_WIDTH-1:0] out_tag
);
  // numer < 2^(Q_WIDTH-1) * denom * 2 holds, so Q_WIDTH quotient bits suffice
  localparam int RW = DEN_WIDTH + 1;

  logic [Q_WIDTH:0]       vld;
  logic [NUM_WIDTH-1:0]   num [Q_WIDTH+1];
  logic [RW-1:0]          rem [Q_WIDTH+1];
  logic [DEN_WIDTH-1:0]   den [Q_WIDTH+1];
  logic [Q_WIDTH-1:0]     q   [Q_WIDTH+1];
  logic [TAG_WIDTH-1:0]   tag [Q_WIDTH+1];

  assign vld[0] = in_valid;
  assign num[0] = numer;
  assign rem[0] = RW'(numer >> Q_WIDTH);
  assign den[0] = denom;
  assign q[0] = '0;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < Q_WIDTH; i++) begin : g_step
    logic [RW:0] trial;
    always_comb trial = {rem[i], num[i][Q_WIDTH-1-i]};
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      num[i+1] <= num[i];
      den[i+1] <= den[i];
      tag[i+1] <= tag[i];
      if (trial >= {2'b00, den[i]}) begin
        rem[i+1] <= RW'(trial - {2'b00, den[i]});
        q[i+1]   <= {q[i][Q_WIDTH-2:0], 1'b1};
      end else begin
        rem[i+1] <= trial[RW-1:0];
        q[i+1]   <= {q[i][Q_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[Q_WIDTH];
  assign quot = q[Q_WIDTH];
  assign out_tag = tag[Q_WIDTH];
endmodule
`default_nettype wire

>>> src/triangle_unit_normal_unit.sv
// Top level of the triangle unit normal pipeline: edges, cross product,
// prescale, square root and three dividers. Uses tun_pkg, tun_sqrt, tun_div.
//
//   channel | handshake        | fields
//   input   | start / busy     | vertex_{a,b,c}_{x,y,z}
//   result  | done (strobe)    | normal_x/y/z, degenerate
//
// One triangle enters every cycle; busy is tied low. The pipeline is built of
// 8 front stages, one stage per root bit of the square root (32), then
// NORMAL_FRAC_BITS+2 divider stages and one output register, which drives
// done. The receiver cannot stall, so the pipeline never holds.
// Synchronous reset clears all valid bits.
`default_nettype none
module triangle_unit_normal_unit #(
  parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
  output logic                          done,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
  output logic                          degenerate
);
  import tun_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int CW = 2 * COORD_WIDTH + 3;
  localparam int MW = CW;
  localparam int BLW = $clog2(CW + 1);
  localparam int SW = PRESCALE_BITS;
  localparam int SQW = 2 * SW + 2;
  localparam int LW = SQW / 2;
  localparam int OW = NORMAL_FRAC_BITS + 2;
  localparam int NW = SW + NORMAL_FRAC_BITS;
  localparam int QW = NORMAL_FRAC_BITS + 2;
  // tag: three signs, degenerate flag, three magnitudes
  localparam int TW = 4 + 3 * SW;

  assign busy = 1'b0;

  // stage 1: edge vectors
  logic v1;
  logic signed [EW-1:0] ux, uy, uz, vx, vy, vz;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    ux <= EW'(vertex_b_x) - EW'(vertex_a_x);
    uy <= EW'(vertex_b_y) - EW'(vertex_a_y);
    uz <= EW'(vertex_b_z) - EW'(vertex_a_z);
    vx <= EW'(vertex_c_x) - EW'(vertex_a_x);
    vy <= EW'(vertex_c_y) - EW'(vertex_a_y);
    vz <= EW'(vertex_c_z) - EW'(vertex_a_z);
  end

  // stage 2: six products
  logic v2;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    p0 <= uy * vz; p1 <= uz * vy;
    p2 <= uz * vx; p3 <= ux * vz;
    p4 <= ux * vy; p5 <= uy * vx;
  end

  // stage 3: cross product components
  logic v3;
  logic signed [CW-1:0] c0, c1, c2;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    c0 <= CW'(p0) - CW'(p1);
    c1 <= CW'(p2) - CW'(p3);
    c2 <= CW'(p4) - CW'(p5);
  end

  // stage 4: signs and magnitudes
  logic v4;
  logic [2:0] ng4;
  logic [MW-1:0] m40, m41, m42;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    ng4 <= {c2[CW-1], c1[CW-1], c0[CW-1]};
    m40 <= c0[CW-1] ? MW'(-c0) : MW'(c0);
    m41 <= c1[CW-1] ? MW'(-c1) : MW'(c1);
    m42 <= c2[CW-1] ? MW'(-c2) : MW'(c2);
  end

  // stage 5: bit length of the largest magnitude
  logic v5;
  logic [2:0] ng5;
  logic [MW-1:0] m50, m51, m52;
  logic [BLW-1:0] top5;
  logic [MW-1:0] ormag;
  logic [BLW-1:0] bl;
  always_comb begin
    ormag = m40 | m41 | m42;
    bl = '0;
    for (int i = 0; i < MW; i++)
      if (ormag[i]) bl = BLW'(i + 1);
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    ng5 <= ng4; m50 <= m40; m51 <= m41; m52 <= m42;
    top5 <= bl;
  end

  // stage 6: prescale shift
  logic v6, dg6;
  logic [2:0] ng6;
  logic [SW-1:0] s60, s61, s62;
  logic [BLW-1:0] sh;
  always_comb sh = (top5 > BLW'(SW)) ? top5 - BLW'(SW) : '0;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    ng6 <= ng5;
    dg6 <= (top5 == '0);
    s60 <= SW'(m50 >> sh);
    s61 <= SW'(m51 >> sh);
    s62 <= SW'(m52 >> sh);
  end

  // stage 7: squares
  logic v7, dg7;
  logic [2:0] ng7;
  logic [SW-1:0] s70, s71, s72;
  logic [2*SW-1:0] q70, q71, q72;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
    ng7 <= ng6; dg7 <= dg6; s70 <= s60; s71 <= s61; s72 <= s62;
    q70 <= {{SW{1'b0}}, s60} * {{SW{1'b0}}, s60};
    q71 <= {{SW{1'b0}}, s61} * {{SW{1'b0}}, s61};
    q72 <= {{SW{1'b0}}, s62} * {{SW{1'b0}}, s62};
  end

  // stage 8: sum of squares
  logic v8;
  logic [SQW-1:0] sum8;
  logic [TW-1:0] tag8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else v8 <= v7;
    sum8 <= SQW'(q70) + SQW'(q71) + SQW'(q72);
    tag8 <= {ng7, dg7, s72, s71, s70};
  end

  logic sq_v;
  logic [LW-1:0] len;
  logic [TW-1:0] sq_tag;
  tun_sqrt #(.IN_WIDTH(SQW), .TAG_WIDTH(TW)) u_sqrt (
    .clk(clk), .rst(rst), .in_valid(v8), .radicand(sum8), .in_tag(tag8),
    .out_valid(sq_v), .root(len), .out_tag(sq_tag)
  );

  // rounding numerators; length forced to one on a zero vector
  logic [SW:0] den;
  logic [NW:0] n0, n1, n2;
  always_comb begin
    den = sq_tag[3*SW] ? (SW+1)'(1) : (SW+1)'(len);
    n0 = {1'b0, sq_tag[SW-1:0], {NORMAL_FRAC_BITS{1'b0}}} + (NW+1)'(den >> 1);
    n1 = {1'b0, sq_tag[2*SW-1:SW], {NORMAL_FRAC_BITS{1'b0}}} + (NW+1)'(den >> 1);
    n2 = {1'b0, sq_tag[3*SW-1:2*SW], {NORMAL_FRAC_BITS{1'b0}}} + (NW+1)'(den >> 1);
  end

  logic dv0, dv1, dv2;
  logic [QW-1:0] qq0, qq1, qq2;
  logic [3:0] dt0, dt1, dt2;
  tun_div #(.NUM_WIDTH(NW+1), .DEN_WIDTH(SW+1), .Q_WIDTH(QW), .TAG_WIDTH(4)) u_div0 (
    .clk(clk), .rst(rst), .in_valid(sq_v), .numer(n0), .denom(den),
    .in_tag(sq_tag[TW-1:3*SW]), .out_valid(dv0), .quot(qq0), .out_tag(dt0));
  tun_div #(.NUM_WIDTH(NW+1), .DEN_WIDTH(SW+1), .Q_WIDTH(QW), .TAG_WIDTH(4)) u_div1 (
    .clk(clk), .rst(rst), .in_valid(sq_v), .numer(n1), .denom(den),
    .in_tag(sq_tag[TW-1:3*SW]), .out_valid(dv1), .quot(qq1), .out_tag(dt1));
  tun_div #(.NUM_WIDTH(NW+1), .DEN_WIDTH(SW+1), .Q_WIDTH(QW), .TAG_WIDTH(4)) u_div2 (
    .clk(clk), .rst(rst), .in_valid(sq_v), .numer(n2), .denom(den),
    .in_tag(sq_tag[TW-1:3*SW]), .out_valid(dv2), .quot(qq2), .out_tag(dt2));

  // output stage: clamp, apply sign, zero on degenerate
  localparam logic [QW-1:0] LIM = QW'(1) << NORMAL_FRAC_BITS;
  logic [QW-1:0] k0, k1, k2;
  always_comb begin
    k0 = (qq0 > LIM) ? LIM : qq0;
    k1 = (qq1 > LIM) ? LIM : qq1;
    k2 = (qq2 > LIM) ? LIM : qq2;
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv0;
    degenerate <= dt0[0];
    normal_x <= dt0[0] ? '0 : (dt0[1] ? OW'(-k0) : OW'(k0));
    normal_y <= dt0[0] ? '0 : (dt0[2] ? OW'(-k1) : OW'(k1));
    normal_z <= dt0[0] ? '0 : (dt0[3] ? OW'(-k2) : OW'(k2));
  end

  localparam int NLIM = 1 << NORMAL_FRAC_BITS;

  // the three dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (dv0 == dv1) && (dv1 == dv2) && (!dv0 || ((dt0 == dt1) && (dt1 == dt2))))
    else $error("divider skew");
  // a degenerate result carries a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate result not zero");
  // a result never exceeds unit magnitude
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= NLIM) && (normal_x >= -NLIM) &&
             (normal_y <= NLIM) && (normal_y >= -NLIM) &&
             (normal_z <= NLIM) && (normal_z >= -NLIM))
    else $error("normal beyond unit magnitude");
  // done is raised in the cycle after a divider output
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    dv0 |=> done) else $error("lost result");
endmodule
`default_nettype wire
